### design/rbs_pkg.sv
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared types, constants and the control program of the RGB box smoother.
// ----------------------------------------------------------------------------
package rbs_pkg;

  // Frame geometry and memory sizing.
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);

  // Field widths.
  localparam int REG_W  = 9;
  localparam int CRD_W  = 8;
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int SUM_W  = 12;
  localparam int PROD_W = 2 * SUM_W;

  // Reset value of every size register.
  localparam logic [REG_W-1:0] REG_RESET = REG_W'(256);

  // Rounding for a divisor of eight or nine: both add four before dividing.
  localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(4);
  // Division by nine as floor(x * 3641 / 2^15), exact for x below 2300.
  localparam logic [SUM_W-1:0] RECIP9      = SUM_W'(3641);
  localparam int               RECIP_SHIFT = 15;
  localparam int               DIV8_SHIFT  = 3;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT  = 2'd1,
    CFG_ACTIVE_WIDTH  = 2'd2,
    CFG_ACTIVE_HEIGHT = 2'd3
  } cfg_idx_t;

  // Item actions.
  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  // Which pixel of the neighborhood the frame address points at.
  typedef enum logic [3:0] {
    NBR_C, NBR_L, NBR_R, NBR_U, NBR_D, NBR_DR, NBR_DL, NBR_UR, NBR_UL
  } nbr_t;

  // Jump conditions of the sequencer.
  typedef enum logic [1:0] {
    COND_NONE, COND_LOAD, COND_PASS, COND_NO_UL
  } cond_t;

  // Channel written by the divide step.
  typedef enum logic [1:0] {
    CH_RED, CH_GREEN, CH_BLUE
  } chan_t;

  // Program steps.
  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t S_ENTRY  = 5'd0;
  localparam step_t S_CENTER = 5'd1;
  localparam step_t S_RD_L   = 5'd2;
  localparam step_t S_RD_R   = 5'd3;
  localparam step_t S_RD_U   = 5'd4;
  localparam step_t S_RD_D   = 5'd5;
  localparam step_t S_RD_DR  = 5'd6;
  localparam step_t S_RD_DL  = 5'd7;
  localparam step_t S_RD_UR  = 5'd8;
  localparam step_t S_RD_UL  = 5'd9;
  localparam step_t S_ACC    = 5'd10;
  localparam step_t S_DIV_R  = 5'd11;
  localparam step_t S_DIV_G  = 5'd12;
  localparam step_t S_DIV_B  = 5'd13;
  localparam step_t S_EMIT   = 5'd14;
  localparam step_t S_PASS   = 5'd15;
  localparam step_t S_LOAD   = 5'd16;

  // Size registers as seen by the datapath.
  typedef struct packed {
    logic [REG_W-1:0] frame_width;
    logic [REG_W-1:0] frame_height;
    logic [REG_W-1:0] active_width;
    logic [REG_W-1:0] active_height;
  } cfg_t;

  // Status flags that steer the program.
  typedef struct packed {
    logic is_load;
    logic pass;
    logic no_ul;
  } flags_t;

  // One control word.
  typedef struct packed {
    nbr_t  nbr;       // address select
    logic  rd_en;     // read the frame at the selected address
    logic  wr_en;     // write the latched pixel at the selected address
    logic  prep;      // register wrapped coordinates and flags
    logic  acc_clr;   // clear the channel sums
    logic  acc_en;    // add the last read pixel to the sums
    logic  div_en;    // divide one channel sum
    chan_t div_ch;
    logic  done;      // present a result next cycle
    logic  src_pass;  // result is the raw stored pixel
    logic  last;      // end of program
    cond_t cond;
    step_t target;
  } ctrl_t;

  // A control word that does nothing.
  function automatic ctrl_t ctrl_nop();
    ctrl_t w;
    w.nbr      = NBR_C;
    w.rd_en    = 1'b0;
    w.wr_en    = 1'b0;
    w.prep     = 1'b0;
    w.acc_clr  = 1'b0;
    w.acc_en   = 1'b0;
    w.div_en   = 1'b0;
    w.div_ch   = CH_RED;
    w.done     = 1'b0;
    w.src_pass = 1'b0;
    w.last     = 1'b0;
    w.cond     = COND_NONE;
    w.target   = S_ENTRY;
    return w;
  endfunction

  // Read-only control store. Reads lead the matching accumulate by one step
  // because the frame read data is registered.
  function automatic ctrl_t program_word(step_t s);
    ctrl_t w;
    w = ctrl_nop();
    unique case (s)
      S_ENTRY: begin
        w.prep   = 1'b1;
        w.cond   = COND_LOAD;
        w.target = S_LOAD;
      end
      S_CENTER: begin
        w.rd_en   = 1'b1;
        w.acc_clr = 1'b1;
        w.cond    = COND_PASS;
        w.target  = S_PASS;
      end
      S_RD_L: begin
        w.nbr = NBR_L;  w.rd_en = 1'b1; w.acc_en = 1'b1;
      end
      S_RD_R: begin
        w.nbr = NBR_R;  w.rd_en = 1'b1; w.acc_en = 1'b1;
      end
      S_RD_U: begin
        w.nbr = NBR_U;  w.rd_en = 1'b1; w.acc_en = 1'b1;
      end
      S_RD_D: begin
        w.nbr = NBR_D;  w.rd_en = 1'b1; w.acc_en = 1'b1;
      end
      S_RD_DR: begin
        w.nbr = NBR_DR; w.rd_en = 1'b1; w.acc_en = 1'b1;
      end
      S_RD_DL: begin
        w.nbr = NBR_DL; w.rd_en = 1'b1; w.acc_en = 1'b1;
      end
      S_RD_UR: begin
        w.nbr    = NBR_UR;
        w.rd_en  = 1'b1;
        w.acc_en = 1'b1;
        w.cond   = COND_NO_UL;
        w.target = S_ACC;
      end
      S_RD_UL: begin
        w.nbr = NBR_UL; w.rd_en = 1'b1; w.acc_en = 1'b1;
      end
      S_ACC: begin
        w.acc_en = 1'b1;
      end
      S_DIV_R: begin
        w.div_en = 1'b1; w.div_ch = CH_RED;
      end
      S_DIV_G: begin
        w.div_en = 1'b1; w.div_ch = CH_GREEN;
      end
      S_DIV_B: begin
        w.div_en = 1'b1; w.div_ch = CH_BLUE;
      end
      S_EMIT: begin
        w.done = 1'b1; w.last = 1'b1;
      end
      S_PASS: begin
        w.done = 1'b1; w.src_pass = 1'b1; w.last = 1'b1;
      end
      S_LOAD: begin
        w.wr_en = 1'b1; w.last = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

### design/rgb_box_smooth_wrap.sv
// ----------------------------------------------------------------------------
// rgb_box_smooth_wrap
// 3x3 box smoothing of a stored RGB frame with wraparound neighbors.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// the item is finished. A load gives no result. A query outside the frame
// or active window returns the stored pixel unsmoothed; a smoothed query
// skips the upper-left read when that neighbor is left out (row or column
// zero). The run time is set by the single frame memory port, which serves
// one neighbor read per step of the control program, and by the shared
// divider, which rounds one channel per step. Each result is shown on
// pixel_out for exactly one cycle while done is high and must be taken then;
// the next item may be started in that same cycle. Configuration writes
// are always ready and must be made only while the block is idle.
module rgb_box_smooth_wrap (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        action,
  input  logic [rbs_pkg::CRD_W-1:0]   column,
  input  logic [rbs_pkg::CRD_W-1:0]   row,
  input  logic [rbs_pkg::PIX_W-1:0]   pixel_in,
  output logic                        done,
  output logic [rbs_pkg::PIX_W-1:0]   pixel_out,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [rbs_pkg::REG_W-1:0]   cfg_data
);

  rbs_pkg::cfg_t   cfg;
  rbs_pkg::ctrl_t  ctrl;
  rbs_pkg::flags_t flags;
  logic            running;
  logic            go;

  assign cfg_ready = 1'b1;
  assign busy      = running;
  assign go        = start && !running;

  // Size registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width   <= rbs_pkg::REG_RESET;
      cfg.frame_height  <= rbs_pkg::REG_RESET;
      cfg.active_width  <= rbs_pkg::REG_RESET;
      cfg.active_height <= rbs_pkg::REG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rbs_pkg::cfg_idx_t'(cfg_index))
        rbs_pkg::CFG_FRAME_WIDTH:   cfg.frame_width   <= cfg_data;
        rbs_pkg::CFG_FRAME_HEIGHT:  cfg.frame_height  <= cfg_data;
        rbs_pkg::CFG_ACTIVE_WIDTH:  cfg.active_width  <= cfg_data;
        rbs_pkg::CFG_ACTIVE_HEIGHT: cfg.active_height <= cfg_data;
        default:                    cfg.active_height <= cfg_data;
      endcase
    end
  end

  // Control program.
  rbs_sequencer u_seq (
    .clk     (clk),
    .rst     (rst),
    .go      (go),
    .flags   (flags),
    .ctrl    (ctrl),
    .running (running)
  );

  // Datapath and frame memory.
  rbs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .action    (action),
    .column    (column),
    .row       (row),
    .pixel_in  (pixel_in),
    .cfg       (cfg),
    .ctrl      (ctrl),
    .flags     (flags),
    .done      (done),
    .pixel_out (pixel_out)
  );

  // An accepted item starts the program in the next cycle.
  a_go_busy: assert property (@(posedge clk) disable iff (rst)
    go |=> busy)
    else $error("accepted item did not start the program");

  // A result only follows a cycle in which the program was running.
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(running))
    else $error("result strobe without a running program");

  // No result can appear right after an item is accepted.
  a_no_early_done: assert property (@(posedge clk) disable iff (rst)
    go |=> !done)
    else $error("result strobe directly after acceptance");

  // Only a finishing control word can release busy.
  a_busy_release: assert property (@(posedge clk) disable iff (rst)
    (running && !ctrl.last) |=> running)
    else $error("program stopped before its last step");

endmodule

### design/rbs_sequencer.sv
// ----------------------------------------------------------------------------
// rbs_sequencer
// Step counter over the control store, with conditional jumps.
// ----------------------------------------------------------------------------
module rbs_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  rbs_pkg::flags_t flags,
  output rbs_pkg::ctrl_t  ctrl,
  output logic            running
);

  rbs_pkg::step_t step;
  rbs_pkg::step_t step_next;
  logic           running_next;
  logic           take;

  // Fetch the current control word; idle cycles issue no operation.
  always_comb begin
    if (running) begin
      ctrl = rbs_pkg::program_word(step);
    end else begin
      ctrl = rbs_pkg::ctrl_nop();
    end
  end

  // Evaluate the jump condition of the current word.
  always_comb begin
    unique case (ctrl.cond)
      rbs_pkg::COND_NONE:  take = 1'b0;
      rbs_pkg::COND_LOAD:  take = flags.is_load;
      rbs_pkg::COND_PASS:  take = flags.pass;
      rbs_pkg::COND_NO_UL: take = flags.no_ul;
      default:             take = 1'b0;
    endcase
  end

  // Next step and run state.
  always_comb begin
    step_next    = step;
    running_next = running;
    if (running) begin
      if (ctrl.last) begin
        running_next = 1'b0;
      end else if (take) begin
        step_next = ctrl.target;
      end else begin
        step_next = step + rbs_pkg::step_t'(1);
      end
    end else if (go) begin
      running_next = 1'b1;
      step_next    = rbs_pkg::S_ENTRY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step    <= rbs_pkg::S_ENTRY;
    end else begin
      running <= running_next;
      step    <= step_next;
    end
  end

endmodule

### design/rbs_datapath.sv
// ----------------------------------------------------------------------------
// rbs_datapath
// Frame memory, neighbor addressing, channel sums and the rounding divider.
// ----------------------------------------------------------------------------
module rbs_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              go,
  input  logic                              action,
  input  logic [rbs_pkg::CRD_W-1:0]         column,
  input  logic [rbs_pkg::CRD_W-1:0]         row,
  input  logic [rbs_pkg::PIX_W-1:0]         pixel_in,
  input  rbs_pkg::cfg_t                     cfg,
  input  rbs_pkg::ctrl_t                    ctrl,
  output rbs_pkg::flags_t                   flags,
  output logic                              done,
  output logic [rbs_pkg::PIX_W-1:0]         pixel_out
);

  localparam int RW = rbs_pkg::REG_W;
  localparam int CW = rbs_pkg::CH_W;
  localparam int SW = rbs_pkg::SUM_W;

  // Latched item.
  logic                      action_q;
  logic [rbs_pkg::CRD_W-1:0] col_q;
  logic [rbs_pkg::CRD_W-1:0] row_q;
  logic [rbs_pkg::PIX_W-1:0] pix_q;

  // Wrapped coordinates and flags, set by the entry step.
  logic [RW-1:0] c_l, c_r, r_u, r_d;
  logic          pass_q;
  logic          ul_ok_q;

  logic [RW-1:0] c9, r9;
  logic [RW-1:0] c_l_next, c_r_next, r_u_next, r_d_next;
  logic [RW-1:0] c_inc, r_inc;
  logic          pass_next;

  // Frame memory and its registered read data.
  logic [rbs_pkg::PIX_W-1:0]  mem [rbs_pkg::DEPTH];
  logic [rbs_pkg::PIX_W-1:0]  rdata;
  logic [RW-1:0]              row_sel, col_sel;
  logic [2*RW-1:0]            row_base;
  logic [rbs_pkg::ADDR_W-1:0] addr;

  // Channel sums and result bytes.
  logic [SW-1:0]              sum_r, sum_g, sum_b;
  logic [SW-1:0]              div_x;
  logic [rbs_pkg::PROD_W-1:0] div_prod;
  logic [CW-1:0]              div_q;
  logic [rbs_pkg::PIX_W-1:0]  res;

  // Capture the item at acceptance.
  always_ff @(posedge clk) begin
    if (go) begin
      action_q <= action;
      col_q    <= column;
      row_q    <= row;
      pix_q    <= pixel_in;
    end
  end

  // Wrapped neighbor coordinates; the center never exceeds the active size
  // on the smoothing path, so a single subtract brings the increment back.
  always_comb begin
    c9    = RW'(col_q);
    r9    = RW'(row_q);
    c_inc = c9 + RW'(1);
    r_inc = r9 + RW'(1);
    c_l_next = (c9 == '0) ? cfg.active_width - RW'(1) : c9 - RW'(1);
    r_u_next = (r9 == '0) ? cfg.active_height - RW'(1) : r9 - RW'(1);
    if (cfg.active_width == RW'(1)) begin
      c_r_next = '0;
    end else if (c_inc >= cfg.active_width) begin
      c_r_next = c_inc - cfg.active_width;
    end else begin
      c_r_next = c_inc;
    end
    if (cfg.active_height == RW'(1)) begin
      r_d_next = '0;
    end else if (r_inc >= cfg.active_height) begin
      r_d_next = r_inc - cfg.active_height;
    end else begin
      r_d_next = r_inc;
    end
    pass_next = (c9 >= cfg.frame_width) || (r9 >= cfg.frame_height) ||
                (cfg.active_width == '0) || (cfg.active_height == '0) ||
                (c9 > cfg.active_width) || (r9 > cfg.active_height);
  end

  always_ff @(posedge clk) begin
    if (ctrl.prep) begin
      c_l     <= c_l_next;
      c_r     <= c_r_next;
      r_u     <= r_u_next;
      r_d     <= r_d_next;
      pass_q  <= pass_next;
      ul_ok_q <= (row_q != '0) && (col_q != '0);
    end
  end

  always_comb begin
    flags.is_load = (rbs_pkg::action_t'(action_q) == rbs_pkg::ACT_LOAD);
    flags.pass    = pass_q;
    flags.no_ul   = !ul_ok_q;
  end

  // Neighbor select and frame address, taken modulo the memory depth.
  always_comb begin
    row_sel = r9;
    col_sel = c9;
    unique case (ctrl.nbr)
      rbs_pkg::NBR_C:  begin row_sel = r9;  col_sel = c9;  end
      rbs_pkg::NBR_L:  begin row_sel = r9;  col_sel = c_l; end
      rbs_pkg::NBR_R:  begin row_sel = r9;  col_sel = c_r; end
      rbs_pkg::NBR_U:  begin row_sel = r_u; col_sel = c9;  end
      rbs_pkg::NBR_D:  begin row_sel = r_d; col_sel = c9;  end
      rbs_pkg::NBR_DR: begin row_sel = r_d; col_sel = c_r; end
      rbs_pkg::NBR_DL: begin row_sel = r_d; col_sel = c_l; end
      rbs_pkg::NBR_UR: begin row_sel = r_u; col_sel = c_r; end
      rbs_pkg::NBR_UL: begin row_sel = r_u; col_sel = c_l; end
      default:         begin row_sel = r9;  col_sel = c9;  end
    endcase
    row_base = row_sel * cfg.frame_width;
    addr     = rbs_pkg::ADDR_W'(row_base + (2*RW)'(col_sel));
  end

  // Single-port frame memory.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[addr] <= pix_q;
    end
    if (ctrl.rd_en) begin
      rdata <= mem[addr];
    end
  end

  // Per-channel sums of the pixels read so far.
  always_ff @(posedge clk) begin
    if (ctrl.acc_clr) begin
      sum_r <= '0;
      sum_g <= '0;
      sum_b <= '0;
    end else if (ctrl.acc_en) begin
      sum_r <= sum_r + SW'(rdata[2*CW +: CW]);
      sum_g <= sum_g + SW'(rdata[CW +: CW]);
      sum_b <= sum_b + SW'(rdata[0 +: CW]);
    end
  end

  // Shared rounding divider: one channel per step, by eight or by nine.
  always_comb begin
    unique case (ctrl.div_ch)
      rbs_pkg::CH_RED:   div_x = sum_r + rbs_pkg::ROUND_BIAS;
      rbs_pkg::CH_GREEN: div_x = sum_g + rbs_pkg::ROUND_BIAS;
      rbs_pkg::CH_BLUE:  div_x = sum_b + rbs_pkg::ROUND_BIAS;
      default:           div_x = sum_b + rbs_pkg::ROUND_BIAS;
    endcase
    div_prod = rbs_pkg::PROD_W'(div_x) * rbs_pkg::PROD_W'(rbs_pkg::RECIP9);
    if (ul_ok_q) begin
      div_q = div_prod[rbs_pkg::RECIP_SHIFT +: CW];
    end else begin
      div_q = div_x[rbs_pkg::DIV8_SHIFT +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.div_en) begin
      unique case (ctrl.div_ch)
        rbs_pkg::CH_RED:   res[2*CW +: CW] <= div_q;
        rbs_pkg::CH_GREEN: res[CW +: CW]   <= div_q;
        rbs_pkg::CH_BLUE:  res[0 +: CW]    <= div_q;
        default:           res[0 +: CW]    <= div_q;
      endcase
    end
  end

  // Result register and its one-cycle strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.done;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.done) begin
      pixel_out <= ctrl.src_pass ? rdata : res;
    end
  end

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wraparound RGB box smoother.
// ----------------------------------------------------------------------------
// Items are queued up front, phase by phase, and fed to the block by a
// clocked driver with random idle bursts. Each accepted item is run through
// a local model of the frame and the smoothing rule, and every query
// pushes its expected pixel. A clocked monitor pops one expected pixel per
// strobed result. The frame geometry changes between phases, only while
// the block is idle. Directed phases cover the smallest geometry, a
// zero-sized active window, the column and row equal to the active size,
// and queries outside the frame or the window. Queries only touch frame
// entries that were loaded earlier.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rbs_pkg::*;

  localparam int ITEM_TARGET   = 1550;
  localparam int QUIET_ITEMS   = 200;
  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT   = 1000;

  // One item as the driver presents it.
  typedef struct packed {
    action_t          act;
    logic [CRD_W-1:0] col;
    logic [CRD_W-1:0] row;
    logic [PIX_W-1:0] pix;
  } pix_op_t;

  // Frame coordinates that a query reads; cnt is 1 for a pass-through,
  // 8 or 9 for a smoothed pixel.
  typedef struct packed {
    logic [3:0]            cnt;
    logic [8:0][CRD_W-1:0] cols;
    logic [8:0][CRD_W-1:0] rows;
  } nbr_set_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic             action;
  logic [CRD_W-1:0] column;
  logic [CRD_W-1:0] row;
  logic [PIX_W-1:0] pixel_in;
  logic             done;
  logic [PIX_W-1:0] pixel_out;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  pix_op_t          cur = '0;
  pix_op_t          pending_q[$];
  logic [PIX_W-1:0] smooth_q[$];
  logic [PIX_W-1:0] frame_mem[0:DEPTH-1];
  bit               loaded[0:DEPTH-1];
  cfg_t             plan_geom = '{REG_RESET, REG_RESET, REG_RESET, REG_RESET};
  cfg_t             live_geom = '{REG_RESET, REG_RESET, REG_RESET, REG_RESET};
  bit               gaps_on = 1'b1;
  int               gap_left = 0;
  int               item_total = 0;
  int               err_count = 0;
  int               stall_cycles = 0;

  assign action   = cur.act;
  assign column   = cur.col;
  assign row      = cur.row;
  assign pixel_in = cur.pix;

  rgb_box_smooth_wrap u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .action    (action),
    .column    (column),
    .row       (row),
    .pixel_in  (pixel_in),
    .done      (done),
    .pixel_out (pixel_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Frame address of a pixel; the row pitch is the stored frame width.
  function automatic logic [ADDR_W-1:0] frame_addr(cfg_t g, logic [CRD_W-1:0] c,
                                                   logic [CRD_W-1:0] r);
    int unsigned a;
    a = int'(r) * int'(g.frame_width) + int'(c);
    return ADDR_W'(a);
  endfunction

  // Which pixels a query reads under geometry g.
  function automatic nbr_set_t nbr_set(cfg_t g, logic [CRD_W-1:0] c, logic [CRD_W-1:0] r);
    nbr_set_t    s;
    int unsigned aw;
    int unsigned ah;
    int unsigned cl;
    int unsigned cr;
    int unsigned ru;
    int unsigned rd;
    s  = '0;
    aw = int'(g.active_width);
    ah = int'(g.active_height);
    s.cols[0] = c;
    s.rows[0] = r;
    if (c >= g.frame_width || r >= g.frame_height || aw == 0 || ah == 0 ||
        int'(c) > aw || int'(r) > ah) begin
      // Outside the frame or the active window: the stored pixel as is.
      s.cnt = 4'd1;
    end else begin
      cl = (int'(c) + aw - 1) % aw;
      cr = (int'(c) + 1) % aw;
      ru = (int'(r) + ah - 1) % ah;
      rd = (int'(r) + 1) % ah;
      s.cnt = 4'd8;
      s.cols[1] = CRD_W'(cl); s.rows[1] = r;
      s.cols[2] = CRD_W'(cr); s.rows[2] = r;
      s.cols[3] = c;          s.rows[3] = CRD_W'(ru);
      s.cols[4] = c;          s.rows[4] = CRD_W'(rd);
      s.cols[5] = CRD_W'(cr); s.rows[5] = CRD_W'(rd);
      s.cols[6] = CRD_W'(cl); s.rows[6] = CRD_W'(rd);
      s.cols[7] = CRD_W'(cr); s.rows[7] = CRD_W'(ru);
      // The upper-left diagonal only counts away from the top row and left column.
      if (r > 0 && c > 0) begin
        s.cols[8] = CRD_W'(cl);
        s.rows[8] = CRD_W'(ru);
        s.cnt     = 4'd9;
      end
    end
    return s;
  endfunction

  // Expected answer to a query: per-channel mean rounded half up.
  function automatic logic [PIX_W-1:0] smoothed_pixel(cfg_t g, logic [CRD_W-1:0] c,
                                                      logic [CRD_W-1:0] r);
    nbr_set_t         nb;
    logic [PIX_W-1:0] p;
    int unsigned      sum_r;
    int unsigned      sum_g;
    int unsigned      sum_b;
    int unsigned      n;
    nb    = nbr_set(g, c, r);
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    n     = int'(nb.cnt);
    if (n == 1) begin
      return frame_mem[frame_addr(g, c, r)];
    end
    for (int i = 0; i < 9; i++) begin
      if (i < n) begin
        p = frame_mem[frame_addr(g, nb.cols[i], nb.rows[i])];
        sum_r += int'(p[23:16]);
        sum_g += int'(p[15:8]);
        sum_b += int'(p[7:0]);
      end
    end
    return {CH_W'((sum_r + n / 2) / n), CH_W'((sum_g + n / 2) / n),
            CH_W'((sum_b + n / 2) / n)};
  endfunction

  // Random pixel with the channel extremes well represented.
  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 24'hFFFFFF;
      1: return 24'h000000;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // Random register value, mostly small so that wrapping happens often.
  function automatic logic [REG_W-1:0] rand_size();
    case ($urandom_range(0, 9))
      0: return REG_W'(1);
      1: return REG_W'(256);
      2, 3: return REG_W'($urandom_range(1, 256));
      default: return REG_W'($urandom_range(1, 12));
    endcase
  endfunction

  // Coordinate near the interesting span, just past it included.
  function automatic logic [CRD_W-1:0] pick_coord(logic [REG_W-1:0] a, logic [REG_W-1:0] b);
    int unsigned span;
    span = (a > b) ? int'(a) : int'(b);
    if (span > 255) span = 255;
    if ($urandom_range(0, 6) == 0) return CRD_W'($urandom_range(0, 255));
    return CRD_W'($urandom_range(0, span));
  endfunction

  task automatic flag_error(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic push_load(input logic [CRD_W-1:0] c, input logic [CRD_W-1:0] r,
                           input logic [PIX_W-1:0] p);
    pending_q.push_back('{ACT_LOAD, c, r, p});
    loaded[frame_addr(plan_geom, c, r)] = 1'b1;
    item_total++;
  endtask

  // A query is preceded by loads of any pixel it reads that was never loaded.
  task automatic push_query(input logic [CRD_W-1:0] c, input logic [CRD_W-1:0] r);
    nbr_set_t nb;
    nb = nbr_set(plan_geom, c, r);
    for (int i = 0; i < 9; i++) begin
      if (i < nb.cnt && !loaded[frame_addr(plan_geom, nb.cols[i], nb.rows[i])]) begin
        push_load(nb.cols[i], nb.rows[i], rand_pixel());
      end
    end
    pending_q.push_back('{ACT_QUERY, c, r, '0});
    item_total++;
  endtask

  // Wait until every item is taken and every result is back. The check is
  // made between rising edges, so the driver's updates are already visible.
  task automatic settle();
    do @(negedge clk);
    while (pending_q.size() != 0 || start || busy || smooth_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four geometry registers back to back.
  task automatic set_geometry(input logic [REG_W-1:0] fw, input logic [REG_W-1:0] fh,
                              input logic [REG_W-1:0] aw, input logic [REG_W-1:0] ah);
    cfg_idx_t idx;
    for (int k = 0; k < 4; k++) begin
      idx = cfg_idx_t'(k);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      case (idx)
        CFG_FRAME_WIDTH:  cfg_data <= fw;
        CFG_FRAME_HEIGHT: cfg_data <= fh;
        CFG_ACTIVE_WIDTH: cfg_data <= aw;
        default:          cfg_data <= ah;
      endcase
      do @(posedge clk);
      while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    plan_geom = '{fw, fh, aw, ah};
  endtask

  // A phase with idle bursts stops where the quiet tail of the run begins.
  task automatic random_items(input int n);
    int stop_at;
    stop_at = gaps_on ? ITEM_TARGET - QUIET_ITEMS : ITEM_TARGET;
    for (int i = 0; i < n && item_total < stop_at; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        push_query(pick_coord(plan_geom.frame_width, plan_geom.active_width),
                   pick_coord(plan_geom.frame_height, plan_geom.active_height));
      end else begin
        push_load(pick_coord(plan_geom.frame_width, plan_geom.active_width),
                  pick_coord(plan_geom.frame_height, plan_geom.active_height), rand_pixel());
      end
    end
  endtask

  // Item driver and local model update on every accepted item.
  always @(posedge clk) begin : drive_items
    pix_op_t nxt;
    if (rst) begin
      start     <= 1'b0;
      gap_left  = 0;
      live_geom = '{REG_RESET, REG_RESET, REG_RESET, REG_RESET};
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FRAME_WIDTH:   live_geom.frame_width   = cfg_data;
          CFG_FRAME_HEIGHT:  live_geom.frame_height  = cfg_data;
          CFG_ACTIVE_WIDTH:  live_geom.active_width  = cfg_data;
          CFG_ACTIVE_HEIGHT: live_geom.active_height = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (cur.act == ACT_LOAD) begin
          frame_mem[frame_addr(live_geom, cur.col, cur.row)] = cur.pix;
        end else begin
          smooth_q.push_back(smoothed_pixel(live_geom, cur.col, cur.row));
        end
      end
      // Present the next item once the current one is taken.
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_q.size() != 0) begin
          nxt   = pending_q.pop_front();
          cur   <= nxt;
          start <= 1'b1;
          if (gaps_on && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 15);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor: every strobed pixel must match the oldest expectation.
  always @(posedge clk) begin : check_results
    logic [PIX_W-1:0] want;
    if (!rst && done) begin
      if (smooth_q.size() == 0) begin
        flag_error($sformatf("pixel %06h with no query outstanding", pixel_out));
      end else begin
        want = smooth_q.pop_front();
        if (pixel_out !== want) begin
          flag_error($sformatf("pixel_out %06h, expected %06h", pixel_out, want));
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset geometry: corners, wrap across the full 256 range, both divisors.
    push_load(8'd0, 8'd0, 24'hFFFFFF);
    push_load(8'd255, 8'd255, 24'h000000);
    push_query(8'd0, 8'd0);
    push_query(8'd255, 8'd255);
    push_query(8'd17, 8'd0);
    settle();

    // Smallest geometry: every neighbor wraps onto the pixel itself.
    set_geometry(9'd1, 9'd1, 9'd1, 9'd1);
    push_query(8'd0, 8'd0);
    push_query(8'd1, 8'd0);
    push_query(8'd0, 8'd1);
    push_query(8'd255, 8'd255);
    settle();

    // Column or row equal to the active size is smoothed; one past it is not.
    set_geometry(9'd8, 9'd8, 9'd5, 9'd5);
    push_query(8'd5, 8'd3);
    push_query(8'd6, 8'd2);
    push_query(8'd3, 8'd5);
    push_query(8'd2, 8'd6);
    push_query(8'd5, 8'd5);
    push_query(8'd9, 8'd1);
    settle();

    // Zero active width, then zero active height: stored pixel comes back.
    set_geometry(9'd4, 9'd4, 9'd0, 9'd4);
    push_query(8'd1, 8'd1);
    settle();
    set_geometry(9'd4, 9'd4, 9'd4, 9'd0);
    push_query(8'd2, 8'd2);
    push_load(8'd2, 8'd2, 24'h80FF01);
    push_query(8'd2, 8'd2);

    // Random phases; the tail of the run has no idle bursts.
    while (item_total < ITEM_TARGET) begin
      settle();
      gaps_on = (item_total < ITEM_TARGET - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
      set_geometry(rand_size(), rand_size(), rand_size(), rand_size());
      random_items($urandom_range(30, 90));
    end
    settle();

    if (err_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
design/rbs_pkg.sv
design/rbs_sequencer.sv
design/rbs_datapath.sv
design/rgb_box_smooth_wrap.sv
dv/tb_top.sv
